@@ sv/rco_pkg.sv @@
// ----------------------------------------------------------------------------
// Rod cutting optimizer package
// Shared widths, codes, sequencer states and the step record that passes
// between the sequencer and the add-compare unit.
// ----------------------------------------------------------------------------
package rco_pkg;

	localparam int MAX_LENGTH = 32;

	// field widths fixed by the interface
	localparam int MODE_W  = 1;
	localparam int PLEN_W  = 6;
	localparam int PRICE_W = 16;
	localparam int ROD_W   = 6;
	localparam int VALUE_W = 21;

	// internal widths
	localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
	localparam int PADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int REV_W   = 22;
	localparam int DP_W    = REV_W + LEN_W;

	localparam logic [ROD_W-1:0]   MAX_ROD   = ROD_W'(MAX_LENGTH);
	localparam logic [REV_W-1:0]   VALUE_MAX = REV_W'(2097151);

	// input mode codes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_SOLVE = 1'b1;

	// result kind codes
	localparam logic KIND_REV = 1'b0;
	localparam logic KIND_CUT = 1'b1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FILL   = 7'b0000010,
		S_DRAIN  = 7'b0000100,
		S_REVRD  = 7'b0001000,
		S_REVOUT = 7'b0010000,
		S_CUTRD  = 7'b0100000,
		S_CUTOUT = 7'b1000000
	} state_t;

	// one candidate cut; its data comes back from the stores in the cycle after it is issued
	typedef struct packed {
		logic             valid;
		logic             first;  // first cut of this length: always taken
		logic             zero;   // remainder is length zero: revenue 0
		logic             pvalid; // price of this piece was loaded
		logic [LEN_W-1:0] cut;
	} step_t;

endpackage

@@ sv/rco_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/rco_acc.sv @@
// ----------------------------------------------------------------------------
// Rod cutting add-compare unit
// Adds piece price to the revenue of the remainder and keeps the running best.
// ----------------------------------------------------------------------------
module rco_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rco_pkg::step_t               step_s1,
	input  logic [rco_pkg::PRICE_W-1:0]  price_rd,
	input  logic [rco_pkg::REV_W-1:0]    best_rd,
	output logic [rco_pkg::REV_W-1:0]    q_next,
	output logic [rco_pkg::LEN_W-1:0]    cut_next
);

	logic [rco_pkg::REV_W-1:0] q_q;
	logic [rco_pkg::LEN_W-1:0] cut_q;
	logic [rco_pkg::REV_W-1:0] price_eff;
	logic [rco_pkg::REV_W-1:0] best_eff;
	logic [rco_pkg::REV_W-1:0] cand;
	logic                      take;

	always_comb begin
		price_eff = step_s1.pvalid ? rco_pkg::REV_W'(price_rd) : '0;
		best_eff  = step_s1.zero ? '0 : best_rd;
		cand      = price_eff + best_eff; // wraps at the revenue width
		// strict greater: on a tie keep the smaller cut
		take      = step_s1.first || (cand > q_q);
		q_next    = take ? cand : q_q;
		cut_next  = take ? step_s1.cut : cut_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q   <= '0;
			cut_q <= '0;
		end else if (step_s1.valid) begin
			q_q   <= q_next;
			cut_q <= cut_next;
		end
	end

endmodule

@@ sv/rod_cutting_optimizer.sv @@
// ----------------------------------------------------------------------------
// Rod cutting optimizer
// Bottom-up rod cutting with a price store, a shared add-compare unit and a
// small sequencer that emits the best revenue followed by the cut pieces.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload                            dir
//  -------  --------------------  ---------------------------------  ---
//  in       in_valid / in_ready   mode, piece_length, price,         in
//                                 rod_length
//  out      out_valid / out_ready kind, value, last                  out
//
// A load beat is taken in the idle state and the block is ready again at once.
// A solve of length L runs L*(L+1)/2 add-compare steps plus one entry write
// per length, set by the single add-compare unit and the single read port
// of each store; then each result beat (revenue, then each cut) passes a read
// state and an output state while the output register drains.
// in_ready is low from the solve beat until the last result sits in the
// output register; a stalled out_ready holds the sequencer in place.
// Reset clears the price valid bits, so every price reads as zero until loaded.
//
module rod_cutting_optimizer (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rco_pkg::MODE_W-1:0]    mode,
	input  logic [rco_pkg::PLEN_W-1:0]    piece_length,
	input  logic [rco_pkg::PRICE_W-1:0]   price,
	input  logic [rco_pkg::ROD_W-1:0]     rod_length,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [rco_pkg::VALUE_W-1:0]   value,
	output logic                          last
);

	localparam int LEN_W   = rco_pkg::LEN_W;
	localparam int PADDR_W = rco_pkg::PADDR_W;
	localparam int REV_W   = rco_pkg::REV_W;
	localparam int DP_W    = rco_pkg::DP_W;
	localparam int VALUE_W = rco_pkg::VALUE_W;

	rco_pkg::state_t state_q;

	logic [LEN_W-1:0] len_q;   // saturated rod length of this solve
	logic [LEN_W-1:0] i_q;     // length being filled
	logic [LEN_W-1:0] j_q;     // first cut being tried
	logic [LEN_W-1:0] rest_q;  // rod left to cut during emission

	logic [rco_pkg::MAX_LENGTH-1:0] pvalid_q;
	rco_pkg::step_t                 step_s1;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 last_q;

	logic                 load_go;
	logic                 solve_go;
	logic                 slot_free;
	logic [LEN_W-1:0]     len_sat;

	logic                 price_we;
	logic [PADDR_W-1:0]   price_waddr;
	logic [PADDR_W-1:0]   price_raddr;
	logic [rco_pkg::PRICE_W-1:0] price_rd;

	logic                 dp_we;
	logic [LEN_W-1:0]     dp_raddr;
	logic [DP_W-1:0]      dp_wdata;
	logic [DP_W-1:0]      dp_rd;
	logic [REV_W-1:0]     best_rd;
	logic [LEN_W-1:0]     fc_rd;

	logic [REV_W-1:0]     q_next;
	logic [LEN_W-1:0]     cut_next;

	logic [LEN_W-1:0]     cut_len;
	logic [REV_W-1:0]     rev_sat;

	logic                 emit;
	logic                 emit_kind;
	logic [VALUE_W-1:0]   emit_value;
	logic                 emit_last;

	// ---------------------------------------------------------------- handshake
	assign in_ready  = (state_q == rco_pkg::S_IDLE);
	assign load_go   = in_valid && in_ready && (mode == rco_pkg::MODE_LOAD);
	assign solve_go  = in_valid && in_ready && (mode == rco_pkg::MODE_SOLVE);
	// a result may enter the output register when it is empty or being taken
	assign slot_free = !out_valid_q || out_ready;

	assign len_sat = (rod_length > rco_pkg::MAX_ROD) ? LEN_W'(rco_pkg::MAX_LENGTH)
	                                                 : LEN_W'(rod_length);

	// ---------------------------------------------------------------- price store
	// lengths outside one to the maximum are dropped
	assign price_we    = load_go && (piece_length != '0) && (piece_length <= rco_pkg::MAX_ROD);
	assign price_waddr = PADDR_W'(piece_length - rco_pkg::PLEN_W'(1));
	assign price_raddr = PADDR_W'(j_q - LEN_W'(1));

	rco_ram #(
		.WIDTH(rco_pkg::PRICE_W),
		.DEPTH(rco_pkg::MAX_LENGTH)
	) u_price_ram (
		.clk  (clk),
		.we   (price_we),
		.waddr(price_waddr),
		.wdata(price),
		.raddr(price_raddr),
		.rdata(price_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (price_we) begin
			pvalid_q[price_waddr] <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- dp store
	// each entry holds {first cut, best revenue}; length zero is never stored,
	// the add-compare unit forces its revenue to zero instead
	assign dp_we    = (state_q == rco_pkg::S_DRAIN);
	assign dp_wdata = {cut_next, q_next};
	assign dp_raddr = (state_q == rco_pkg::S_FILL) ? (i_q - j_q) : rest_q;

	rco_ram #(
		.WIDTH(DP_W),
		.DEPTH(rco_pkg::MAX_LENGTH + 1)
	) u_dp_ram (
		.clk  (clk),
		.we   (dp_we),
		.waddr(i_q),
		.wdata(dp_wdata),
		.raddr(dp_raddr),
		.rdata(dp_rd)
	);

	assign best_rd = dp_rd[REV_W-1:0];
	assign fc_rd   = dp_rd[DP_W-1:REV_W];

	// ---------------------------------------------------------------- add-compare
	rco_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_s1 (step_s1),
		.price_rd(price_rd),
		.best_rd (best_rd),
		.q_next  (q_next),
		.cut_next(cut_next)
	);

	// ---------------------------------------------------------------- emission
	always_comb begin
		// a missing or oversized first cut takes the whole remainder
		cut_len = ((fc_rd == '0) || (fc_rd > rest_q)) ? rest_q : fc_rd;
		rev_sat = (best_rd > rco_pkg::VALUE_MAX) ? rco_pkg::VALUE_MAX : best_rd;

		emit       = 1'b0;
		emit_kind  = rco_pkg::KIND_REV;
		emit_value = '0;
		emit_last  = 1'b0;
		unique case (state_q)
			rco_pkg::S_REVOUT: begin
				emit       = slot_free;
				emit_kind  = rco_pkg::KIND_REV;
				emit_value = (len_q == '0) ? '0 : VALUE_W'(rev_sat);
				emit_last  = (len_q == '0);
			end
			rco_pkg::S_CUTOUT: begin
				emit       = slot_free;
				emit_kind  = rco_pkg::KIND_CUT;
				emit_value = VALUE_W'(cut_len);
				emit_last  = (cut_len == rest_q);
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rco_pkg::S_IDLE;
			len_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			rest_q  <= '0;
			step_s1 <= '0;
		end else begin
			// a candidate is issued on every fill cycle and on no other
			step_s1.valid <= (state_q == rco_pkg::S_FILL);
			unique case (state_q)
				rco_pkg::S_IDLE: begin
					if (solve_go) begin
						len_q   <= len_sat;
						rest_q  <= len_sat;
						i_q     <= LEN_W'(1);
						j_q     <= LEN_W'(1);
						state_q <= (len_sat == '0) ? rco_pkg::S_REVRD : rco_pkg::S_FILL;
					end
				end
				rco_pkg::S_FILL: begin
					// issue one candidate cut; its data returns next cycle
					step_s1.first  <= (j_q == LEN_W'(1));
					step_s1.zero   <= (j_q == i_q);
					step_s1.pvalid <= pvalid_q[price_raddr];
					step_s1.cut    <= j_q;
					if (j_q == i_q) begin
						state_q <= rco_pkg::S_DRAIN;
					end else begin
						j_q <= j_q + LEN_W'(1);
					end
				end
				rco_pkg::S_DRAIN: begin
					// fold in the last candidate and write the entry for this length
					if (i_q == len_q) begin
						state_q <= rco_pkg::S_REVRD;
					end else begin
						i_q     <= i_q + LEN_W'(1);
						j_q     <= LEN_W'(1);
						state_q <= rco_pkg::S_FILL;
					end
				end
				rco_pkg::S_REVRD: begin
					state_q <= rco_pkg::S_REVOUT;
				end
				rco_pkg::S_REVOUT: begin
					if (slot_free) begin
						state_q <= (len_q == '0) ? rco_pkg::S_IDLE : rco_pkg::S_CUTRD;
					end
				end
				rco_pkg::S_CUTRD: begin
					state_q <= rco_pkg::S_CUTOUT;
				end
				rco_pkg::S_CUTOUT: begin
					if (slot_free) begin
						rest_q  <= rest_q - cut_len;
						state_q <= (cut_len == rest_q) ? rco_pkg::S_IDLE : rco_pkg::S_CUTRD;
					end
				end
				default: begin
					state_q <= rco_pkg::S_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= emit_kind;
			value_q <= emit_value;
			last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign last      = last_q;

	// ---------------------------------------------------------------- assertions
	// no candidate may still be in flight once the block takes a new beat
	a_idle_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !step_s1.valid)
		else $error("candidate in flight while idle");

	// the entry write always has the last candidate of its length to fold in
	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rco_pkg::S_DRAIN) |-> (step_s1.valid && step_s1.zero))
		else $error("entry written without its last candidate");

	// the cut index stays within one and the length being filled
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rco_pkg::S_FILL) |-> ((j_q != '0) && (j_q <= i_q) && (i_q <= len_q)))
		else $error("cut index out of range");

	// a result is never overwritten before it has been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$rose(last_q) || $past(!out_valid_q))
		else $error("result overwritten while stalled");

endmodule
